>>> hw/rtl/utf8td_pkg.sv
// ----------------------------------------------------------------------------
// utf8td_pkg: shared types and constants for the UTF-8 text detector
// Holds the request and response transaction types, the verdict codes and
// the byte constants and the continuation-byte test used by the detection checks.
// ----------------------------------------------------------------------------
package utf8td_pkg;

   // Request transaction: one byte of the buffer plus the end-of-buffer flag
   typedef struct packed {
      logic [7:0] data_byte;
      logic       is_last;
   } req_type;

   // Response transaction: one verdict per buffer
   typedef struct packed {
      logic       is_utf8;
      logic [3:0] verdict;
   } rsp_type;

   // Verdict codes, in check order
   localparam logic [3:0] VERDICT_SHORT      = 4'd0;
   localparam logic [3:0] VERDICT_ZERO_WORD  = 4'd1;
   localparam logic [3:0] VERDICT_UTF16_MARK = 4'd2;
   localparam logic [3:0] VERDICT_TOO_SHORT  = 4'd3;
   localparam logic [3:0] VERDICT_UTF8_MARK  = 4'd4;
   localparam logic [3:0] VERDICT_ILLEGAL    = 4'd5;
   localparam logic [3:0] VERDICT_BAD_CONT   = 4'd6;
   localparam logic [3:0] VERDICT_MULTIBYTE  = 4'd7;
   localparam logic [3:0] VERDICT_PLAIN      = 4'd8;

   // Byte-order marks and byte patterns
   localparam logic [15:0] UTF16_MARK     = 16'hFEFF;
   localparam logic [15:0] UTF8_MARK_LOW  = 16'hBBEF;
   localparam logic [7:0]  UTF8_MARK_HIGH = 8'hBF;
   localparam logic [7:0]  BYTE_C0        = 8'hC0;
   localparam logic [7:0]  BYTE_C1        = 8'hC1;
   localparam logic [7:0]  BYTE_F5        = 8'hF5;

   // Number of bytes seen saturates here; scanning starts once reached
   localparam logic [1:0] SEEN_FULL = 2'd3;

   // Continuation byte: 10xxxxxx
   function automatic logic is_cont(input logic [7:0] b);
      return b[7:6] == 2'b10;
   endfunction

endpackage

>>> hw/rtl/utf8_text_detector_unit.sv
// ----------------------------------------------------------------------------
// utf8_text_detector_unit: streaming UTF-8 text detector
// Takes a buffer one byte per transaction and returns a single verdict
// transaction when the byte flagged as last has been taken.
// ----------------------------------------------------------------------------
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | data_byte, is_last
//   rsp     | out       | rsp_valid/rsp_stall | is_utf8, verdict
//
// One byte is taken per cycle unless stalled; per-byte checks run between
// the state registers and the response register, so the verdict appears in
// the cycle after the last byte is taken. Reset clears all scan state and the
// response valid flag. A stalled response holds req_stall high only for
// a last byte, the one byte that needs the occupied response register.
// ----------------------------------------------------------------------------
module utf8_text_detector_unit
   import utf8td_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Scan state
   logic [1:0]  bytes_seen_ff, bytes_seen_in;
   logic [23:0] leading_ff, leading_in;
   logic [7:0]  win0_ff, win1_ff, win2_ff;
   logic        odd_ff, odd_in;
   logic        pend_ff, pend_in;
   logic        zero_word_ff, zero_word_in;
   logic        illegal_ff, illegal_in;
   logic        broken_ff, broken_in;
   logic        multi_ff, multi_in;
   logic [1:0]  due_ff, due_in;

   // Response register
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        req_take;
   logic [7:0]  b;
   logic [3:0]  verdict;

   assign b         = req_data.data_byte;
   assign req_stall = rsp_valid_ff && rsp_stall && req_data.is_last;
   assign req_take  = req_valid && !req_stall;

   // Per-byte checks and next scan state
   always_comb begin
      logic scan_en;
      logic ok;
      logic [1:0] need;
      logic is_lead;
      scan_en   = bytes_seen_ff == SEEN_FULL;
      ok        = 1'b0;
      need      = 2'd0;
      is_lead   = 1'b0;
      multi_in  = multi_ff;
      broken_in = broken_ff;
      due_in    = due_ff;

      // classify the oldest held byte as a lead
      if (win0_ff[7:5] == 3'b110) begin
         is_lead = 1'b1;
         need    = 2'd1;
         ok      = is_cont(win1_ff);
      end else if (win0_ff[7:4] == 4'b1110) begin
         is_lead = 1'b1;
         need    = 2'd2;
         ok      = is_cont(win1_ff) && is_cont(win2_ff);
      end else if (win0_ff[7:3] == 5'b11110) begin
         is_lead = 1'b1;
         need    = 2'd3;
         ok      = is_cont(win1_ff) && is_cont(win2_ff) && is_cont(b);
      end

      // skip claimed continuations, else judge the lead
      if (scan_en) begin
         if (due_ff != 2'd0) begin
            due_in = due_ff - 2'd1;
         end else if (is_lead) begin
            if (ok) begin
               multi_in = 1'b1;
               due_in   = need;
            end else begin
               broken_in = 1'b1;
            end
         end
      end

      zero_word_in = zero_word_ff || pend_ff;
      pend_in      = odd_ff && (win2_ff == 8'd0) && (b == 8'd0);
      odd_in       = !odd_ff;
      illegal_in   = illegal_ff || (b == BYTE_C0) || (b == BYTE_C1) || (b >= BYTE_F5);

      // capture the first three bytes
      leading_in    = leading_ff;
      bytes_seen_in = bytes_seen_ff;
      case (bytes_seen_ff)
         2'd0: begin
            leading_in[7:0] = b;
            bytes_seen_in   = 2'd1;
         end
         2'd1: begin
            leading_in[15:8] = b;
            bytes_seen_in    = 2'd2;
         end
         2'd2: begin
            leading_in[23:16] = b;
            bytes_seen_in     = SEEN_FULL;
         end
         default: begin
            bytes_seen_in = SEEN_FULL;
         end
      endcase
   end

   // Verdict for a buffer ending on this byte
   always_comb begin
      if (bytes_seen_ff == 2'd0) begin
         verdict = VERDICT_SHORT;
      end else if (zero_word_in) begin
         verdict = VERDICT_ZERO_WORD;
      end else if (leading_in[15:0] == UTF16_MARK) begin
         verdict = VERDICT_UTF16_MARK;
      end else if (bytes_seen_ff == 2'd1) begin
         verdict = VERDICT_TOO_SHORT;
      end else if (leading_in[15:0] == UTF8_MARK_LOW &&
                   leading_in[23:16] == UTF8_MARK_HIGH) begin
         verdict = VERDICT_UTF8_MARK;
      end else if (illegal_in) begin
         verdict = VERDICT_ILLEGAL;
      end else if (broken_in) begin
         verdict = VERDICT_BAD_CONT;
      end else if (multi_in) begin
         verdict = VERDICT_MULTIBYTE;
      end else begin
         verdict = VERDICT_PLAIN;
      end
   end

   // Response register: load on a taken last byte, drop when delivered
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (req_take && req_data.is_last) begin
         rsp_valid_in   = 1'b1;
         rsp_in.verdict = verdict;
         rsp_in.is_utf8 = (verdict == VERDICT_SHORT) || (verdict == VERDICT_UTF8_MARK) ||
                          (verdict == VERDICT_MULTIBYTE);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Advance scan state on each taken byte; clear it after the last byte
   always_ff @(posedge clock) begin
      if (reset || (req_take && req_data.is_last)) begin
         bytes_seen_ff <= 2'd0;
         leading_ff    <= 24'd0;
         win0_ff       <= 8'd0;
         win1_ff       <= 8'd0;
         win2_ff       <= 8'd0;
         odd_ff        <= 1'b0;
         pend_ff       <= 1'b0;
         zero_word_ff  <= 1'b0;
         illegal_ff    <= 1'b0;
         broken_ff     <= 1'b0;
         multi_ff      <= 1'b0;
         due_ff        <= 2'd0;
      end else if (req_take) begin
         bytes_seen_ff <= bytes_seen_in;
         leading_ff    <= leading_in;
         win0_ff       <= win1_ff;
         win1_ff       <= win2_ff;
         win2_ff       <= b;
         odd_ff        <= odd_in;
         pend_ff       <= pend_in;
         zero_word_ff  <= zero_word_in;
         illegal_ff    <= illegal_in;
         broken_ff     <= broken_in;
         multi_ff      <= multi_in;
         due_ff        <= due_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

`ifndef SYNTH
   // A verdict only appears after a last byte was taken
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_valid && !req_stall && req_data.is_last))
      else $error("response without a taken last byte");

   // Scan state is cleared for the next buffer
   assert property (@(posedge clock) disable iff (reset)
      (req_take && req_data.is_last) |=> (bytes_seen_ff == 2'd0 && due_ff == 2'd0))
      else $error("scan state not cleared after last byte");

   // Pending continuations only exist once scanning has started
   assert property (@(posedge clock) disable iff (reset)
      (due_ff != 2'd0) |-> (bytes_seen_ff == SEEN_FULL))
      else $error("continuations pending before scan start");

   // The text flag agrees with the verdict code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.is_utf8 == ((rsp_ff.verdict == VERDICT_SHORT) ||
         (rsp_ff.verdict == VERDICT_UTF8_MARK) || (rsp_ff.verdict == VERDICT_MULTIBYTE))))
      else $error("is_utf8 disagrees with verdict");
`endif

endmodule

>>> verif/utf8_text_detector_unit_tb.sv
// ----------------------------------------------------------------------------
// utf8_text_detector_unit_tb: self-checking bench for the UTF-8 text detector
// Streams byte buffers into the detector, predicts each buffer's verdict
// from a software copy of the scan state, and checks every response
// transaction in order. Handshake idling on both channels varies by phase.
// ----------------------------------------------------------------------------
module utf8_text_detector_unit_tb
   import utf8td_pkg::*;
();

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_BYTES = 1600;

   // Verdict predictor and in-order store of expected verdicts
   class verdict_board;
      logic [1:0]  bytes_seen;
      logic [23:0] leading_bytes;
      logic [7:0]  window [3];
      logic        odd_offset;
      logic        zero_pair_pending;
      logic        zero_word_found;
      logic        illegal_found;
      logic        sequence_broken;
      logic        multibyte_found;
      logic [1:0]  skip_count;
      rsp_type     pending_verdicts [$];
      int          error_count;

      function new();
         error_count = 0;
         clear();
      endfunction

      function void clear();
         bytes_seen        = '0;
         leading_bytes     = '0;
         window[0]         = '0;
         window[1]         = '0;
         window[2]         = '0;
         odd_offset        = 1'b0;
         zero_pair_pending = 1'b0;
         zero_word_found   = 1'b0;
         illegal_found     = 1'b0;
         sequence_broken   = 1'b0;
         multibyte_found   = 1'b0;
         skip_count        = '0;
      endfunction

      function logic tail_byte(input logic [7:0] c);
         return c[7:6] == 2'b10;
      endfunction

      // Judge the oldest held byte as a lead, newest byte as third follower
      function void scan_lead(input logic [7:0] c3);
         logic [7:0] lead;
         logic [7:0] c1;
         logic [7:0] c2;
         logic [1:0] need;
         logic       ok;
         lead = window[0];
         c1   = window[1];
         c2   = window[2];
         if (skip_count != 0) begin
            skip_count = skip_count - 1'b1;
            return;
         end
         if (lead[7:5] == 3'b110) begin
            need = 2'd1;
            ok   = tail_byte(c1);
         end else if (lead[7:4] == 4'b1110) begin
            need = 2'd2;
            ok   = tail_byte(c1) && tail_byte(c2);
         end else if (lead[7:3] == 5'b11110) begin
            need = 2'd3;
            ok   = tail_byte(c1) && tail_byte(c2) && tail_byte(c3);
         end else begin
            return;
         end
         if (ok) begin
            multibyte_found = 1'b1;
            skip_count      = need;
         end else begin
            sequence_broken = 1'b1;
         end
      endfunction

      // Note an accepted byte; queue a verdict on the final one
      function void take_byte(input req_type r);
         logic [7:0] b;
         logic [1:0] seen;
         logic [3:0] v;
         rsp_type    exp_rsp;
         b    = r.data_byte;
         seen = bytes_seen;
         if (seen == SEEN_FULL) scan_lead(b);
         if (zero_pair_pending) zero_word_found = 1'b1;
         zero_pair_pending = odd_offset && window[2] == 8'h00 && b == 8'h00;
         odd_offset = !odd_offset;
         if (b == BYTE_C0 || b == BYTE_C1 || b >= BYTE_F5) illegal_found = 1'b1;
         if (seen != SEEN_FULL) begin
            leading_bytes[8*seen +: 8] = b;
            bytes_seen = seen + 2'd1;
         end
         window[0] = window[1];
         window[1] = window[2];
         window[2] = b;
         if (!r.is_last) return;

         if (seen == 2'd0) begin
            v = VERDICT_SHORT;
         end else if (zero_word_found) begin
            v = VERDICT_ZERO_WORD;
         end else if (leading_bytes[15:0] == UTF16_MARK) begin
            v = VERDICT_UTF16_MARK;
         end else if (seen == 2'd1) begin
            v = VERDICT_TOO_SHORT;
         end else if (leading_bytes[15:0] == UTF8_MARK_LOW &&
                      leading_bytes[23:16] == UTF8_MARK_HIGH) begin
            v = VERDICT_UTF8_MARK;
         end else if (illegal_found) begin
            v = VERDICT_ILLEGAL;
         end else if (sequence_broken) begin
            v = VERDICT_BAD_CONT;
         end else if (multibyte_found) begin
            v = VERDICT_MULTIBYTE;
         end else begin
            v = VERDICT_PLAIN;
         end
         exp_rsp.verdict = v;
         exp_rsp.is_utf8 = (v == VERDICT_SHORT || v == VERDICT_UTF8_MARK ||
                            v == VERDICT_MULTIBYTE);
         pending_verdicts.push_back(exp_rsp);
         clear();
      endfunction

      // Compare a response transaction against the oldest expected verdict
      function void check_verdict(input rsp_type r);
         rsp_type exp_rsp;
         if (pending_verdicts.size() == 0) begin
            $error("verdict arrived with none expected: is_utf8 %0d verdict %0d",
                   r.is_utf8, r.verdict);
            error_count++;
            return;
         end
         exp_rsp = pending_verdicts.pop_front();
         if (r.is_utf8 !== exp_rsp.is_utf8) begin
            $error("is_utf8 mismatch: expected %0d, actual %0d",
                   exp_rsp.is_utf8, r.is_utf8);
            error_count++;
         end
         if (r.verdict !== exp_rsp.verdict) begin
            $error("verdict mismatch: expected %0d, actual %0d",
                   exp_rsp.verdict, r.verdict);
            error_count++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   int           bytes_sent = 0;
   int           cycle_count = 0;
   logic [7:0]   buffer_bytes [$];
   verdict_board board;

   utf8_text_detector_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Stall the response channel at random
   always @(negedge clock) begin
      rsp_stall = ($urandom_range(99) < recv_idle_pct);
   end

   // Observe both channels at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.take_byte(req_data);
         if (rsp_valid && !rsp_stall) board.check_verdict(rsp_data);
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("utf8_text_detector_unit_tb failed");
         $finish;
      end
   end

   // Drive one byte transaction; called and returns at a falling edge
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid         = 1'b1;
      req_data.data_byte = b;
      req_data.is_last  = last;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_buffer();
      int n;
      n = buffer_bytes.size();
      for (int i = 0; i < n; i++) send_byte(buffer_bytes[i], i == n - 1);
   endtask

   function automatic logic [7:0] ascii_byte();
      if ($urandom_range(15) == 0) return 8'h00;
      return 8'($urandom_range(8'h7F, 8'h01));
   endfunction

   function automatic logic [7:0] follow_byte();
      return 8'h80 | 8'($urandom_range(63));
   endfunction

   // Append well-formed sequences, with an odd stray continuation
   task automatic add_sequences(input int count);
      for (int s = 0; s < count; s++) begin
         case ($urandom_range(9))
            0, 1, 2, 3: buffer_bytes.push_back(ascii_byte());
            4, 5: begin
               buffer_bytes.push_back(8'($urandom_range(8'hDF, 8'hC2)));
               buffer_bytes.push_back(follow_byte());
            end
            6, 7: begin
               buffer_bytes.push_back(8'($urandom_range(8'hEF, 8'hE0)));
               repeat (2) buffer_bytes.push_back(follow_byte());
            end
            8: begin
               buffer_bytes.push_back(8'($urandom_range(8'hF4, 8'hF0)));
               repeat (3) buffer_bytes.push_back(follow_byte());
            end
            default: buffer_bytes.push_back(follow_byte());
         endcase
      end
      repeat ($urandom_range(3)) buffer_bytes.push_back(ascii_byte());
   endtask

   task automatic make_random_buffer();
      int kind;
      int count;
      int len;
      logic [7:0] pick [8];
      pick = '{8'h00, 8'hFF, 8'hFE, 8'hEF, 8'hBB, 8'hBF, 8'hC3, 8'h41};
      buffer_bytes.delete();
      kind  = $urandom_range(99);
      count = ($urandom_range(9) == 0) ? $urandom_range(30, 9) : $urandom_range(8, 1);
      if (kind < 55) begin
         add_sequences(count);
      end else if (kind < 67) begin
         // byte-order mark, then content
         if ($urandom_range(1)) begin
            buffer_bytes.push_back(8'hFF);
            buffer_bytes.push_back(8'hFE);
         end else begin
            buffer_bytes.push_back(8'hEF);
            buffer_bytes.push_back(8'hBB);
            if ($urandom_range(3) != 0) buffer_bytes.push_back(8'hBF);
         end
         if ($urandom_range(1)) add_sequences($urandom_range(4));
      end else if (kind < 77) begin
         len = $urandom_range(12, 1);
         repeat (len) buffer_bytes.push_back(8'($urandom));
      end else if (kind < 90) begin
         // break one byte of a well-formed buffer
         add_sequences(count);
         buffer_bytes[$urandom_range(buffer_bytes.size() - 1)] = 8'($urandom);
      end else begin
         len = $urandom_range(4, 1);
         repeat (len) buffer_bytes.push_back(pick[$urandom_range(7)]);
      end
      if (buffer_bytes.size() == 0) buffer_bytes.push_back(ascii_byte());
   endtask

   task automatic run_directed();
      for (int d = 0; d < 9; d++) begin
         case (d)
            0: buffer_bytes = '{8'h41};
            1: buffer_bytes = '{8'h00, 8'h00};
            2: buffer_bytes = '{8'hFF, 8'hFE};
            3: buffer_bytes = '{8'hEF, 8'hBB, 8'hBF};
            4: buffer_bytes = '{8'h00, 8'h00, 8'h41};
            5: buffer_bytes = '{8'hC3, 8'hA9, 8'h41, 8'h42};
            6: buffer_bytes = '{8'hC0, 8'h41, 8'h42};
            7: buffer_bytes = '{8'hE2, 8'h41, 8'h42, 8'h43};
            default: buffer_bytes = '{8'h80, 8'h41, 8'h42};
         endcase
         send_buffer();
      end
   endtask

   initial begin
      int phase_target;
      board = new;

      // hold reset, then release at a falling edge
      repeat (10) @(negedge clock);
      reset = 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 7;
               recv_idle_pct = 62;
            end
            1: begin
               send_idle_pct = 62;
               recv_idle_pct = 7;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         if (phase == 0) run_directed();
         phase_target = bytes_sent + RANDOM_BYTES / 3;
         while (bytes_sent < phase_target) begin
            make_random_buffer();
            send_buffer();
         end
      end
      req_valid = 1'b0;

      // drain outstanding verdicts, then allow the response latency
      while (board.pending_verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (board.error_count == 0 && board.pending_verdicts.size() == 0) begin
         $display("utf8_text_detector_unit_tb passed");
      end else begin
         $display("utf8_text_detector_unit_tb failed");
      end
      $finish;
   end

endmodule
